// ----- rtl/owtr_pkg.sv -----
// ============================================================================
// owtr_pkg
// Shared types, command codes and register indexes for the 1-Wire
// temperature reader.
// ============================================================================
package owtr_pkg;

    // Configuration register file
    localparam int REG_COUNT     = 8;
    localparam int REG_WIDTH     = 10;
    localparam int REG_IDX_WIDTH = 3;

    typedef logic [REG_WIDTH-1:0]                 reg_val_t;
    typedef logic [REG_IDX_WIDTH-1:0]             reg_idx_t;
    typedef logic [REG_COUNT-1:0][REG_WIDTH-1:0]  cfg_regs_t;

    // Register indexes
    localparam reg_idx_t REG_RESET_LOW       = 3'd0;
    localparam reg_idx_t REG_PRESENCE_SAMPLE = 3'd1;
    localparam reg_idx_t REG_PRESENCE_REST   = 3'd2;
    localparam reg_idx_t REG_WRITE_LOW       = 3'd3;
    localparam reg_idx_t REG_WRITE_REST      = 3'd4;
    localparam reg_idx_t REG_READ_LOW        = 3'd5;
    localparam reg_idx_t REG_READ_SAMPLE     = 3'd6;
    localparam reg_idx_t REG_READ_REST       = 3'd7;

    // Register reset values in microseconds
    localparam reg_val_t RST_RESET_LOW       = 10'd480;
    localparam reg_val_t RST_PRESENCE_SAMPLE = 10'd60;
    localparam reg_val_t RST_PRESENCE_REST   = 10'd420;
    localparam reg_val_t RST_WRITE_LOW       = 10'd5;
    localparam reg_val_t RST_WRITE_REST      = 10'd56;
    localparam reg_val_t RST_READ_LOW        = 10'd1;
    localparam reg_val_t RST_READ_SAMPLE     = 10'd14;
    localparam reg_val_t RST_READ_REST       = 10'd45;

    // 1-Wire command bytes
    localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
    localparam logic [7:0] CMD_CONVERT      = 8'h44;
    localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

    // Steps of the read sequence
    typedef logic [3:0] stage_t;
    localparam stage_t STAGE_RESET0   = 4'd0;
    localparam stage_t STAGE_SKIP0    = 4'd1;
    localparam stage_t STAGE_CONVERT  = 4'd2;
    localparam stage_t STAGE_POLL     = 4'd3;
    localparam stage_t STAGE_RESET1   = 4'd4;
    localparam stage_t STAGE_SKIP1    = 4'd5;
    localparam stage_t STAGE_READ_CMD = 4'd6;
    localparam stage_t STAGE_BYTE0    = 4'd7;
    localparam stage_t STAGE_BYTE1    = 4'd8;
    localparam stage_t STAGE_LAST     = 4'd9;

    // Parts of one slot
    typedef enum logic [1:0] {
        PART_LOW    = 2'd0,
        PART_SAMPLE = 2'd1,
        PART_REST   = 2'd2
    } part_t;

    typedef enum logic [1:0] {
        KIND_RESET = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    localparam logic [13:0] FRACTION_SCALE = 14'd625;

    // One result of the sequencer for one tick
    typedef struct packed {
        logic        drive_low;
        logic        busy;
        logic        done;
        logic        ok;
        logic [7:0]  whole;
        logic [13:0] fraction;
    } step_res_t;

    function automatic kind_t stage_kind(input stage_t stage);
        kind_t k;
        unique case (stage)
            STAGE_RESET0, STAGE_RESET1, STAGE_LAST:             k = KIND_RESET;
            STAGE_SKIP0, STAGE_CONVERT, STAGE_SKIP1,
            STAGE_READ_CMD:                                     k = KIND_WRITE;
            default:                                            k = KIND_READ;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] stage_command(input stage_t stage);
        logic [7:0] c;
        unique case (stage)
            STAGE_CONVERT:  c = CMD_CONVERT;
            STAGE_READ_CMD: c = CMD_READ_SCRATCH;
            default:        c = CMD_SKIP_ROM;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/onewire_temperature_reader_top.sv -----
// ============================================================================
// onewire_temperature_reader_top
// 1-Wire bus master that runs a temperature conversion and reads the result,
// advancing by one microsecond tick per input word.
// ============================================================================
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  tdata[0] bus_level, tuser[0] opcode
//  m_*       out        m_tvalid/m_tready  drive_low, busy, done, ok, degrees
//  cfg_*     in         cfg_we             cfg_index, cfg_data (10 bits)
//
//  Each tick word passes through the input register and then the result
//  register; one word per cycle is sustained while m_tready stays high, set by
//  the single pass of sequencer logic between the two.
//  Reset clears the sequencer to idle and loads the default timing.
//  A stalled result register holds the input register, which then drops
//  s_tready; configuration writes are accepted every cycle.
//
module onewire_temperature_reader_top
    import owtr_pkg::*;
#(
    parameter int TIMER_BITS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] bus_level, [7:1] zero
    input  logic [0:0]  s_tuser,    // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [0] drive_low, [1] busy_res, [2] done_res,
                                    // [3] ok, [11:4] whole_degrees,
                                    // [25:12] fraction_ten_thousandths, [31:26] zero
    input  logic        cfg_we,
    input  reg_idx_t    cfg_index,
    input  reg_val_t    cfg_data
);

    logic      in_valid_reg;
    logic      in_opcode_reg;
    logic      in_bus_reg;
    logic      out_valid_reg;
    step_res_t out_reg;
    logic      move;
    cfg_regs_t regs;
    step_res_t step_res;

    // A word moves forward when the result register is free or draining.
    assign move     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || move;

    owtr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    owtr_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (move),
        .opcode    (in_opcode_reg),
        .bus_level (in_bus_reg),
        .regs      (regs),
        .res       (step_res)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_opcode_reg <= s_tuser[0];
            in_bus_reg    <= s_tdata[0];
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.fraction, out_reg.whole, out_reg.ok,
                       out_reg.done, out_reg.busy, out_reg.drive_low};

`ifndef SYNTHESIS
    // A finished sequence always leaves the bus idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        move && step_res.done |-> !step_res.busy)
        else $error("done reported while sequence still busy");

    // Every tick taken from the input register shows up as a result.
    a_move_out: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> m_tvalid)
        else $error("tick taken without a result");

    // A held input word stays put until the result side frees up.
    a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !move |=> in_valid_reg && $stable(in_bus_reg)
        && $stable(in_opcode_reg))
        else $error("input register lost a stalled word");
`endif

endmodule

// ----- rtl/owtr_cfg.sv -----
// ============================================================================
// owtr_cfg
// Timing register file: eight 10-bit durations with write-only access.
// ============================================================================
module owtr_cfg
    import owtr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  reg_idx_t  cfg_index,
    input  reg_val_t  cfg_data,
    output cfg_regs_t regs
);

    cfg_regs_t regs_reg;

    // Registers load at reset defaults and take writes at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg[REG_RESET_LOW]       <= RST_RESET_LOW;
            regs_reg[REG_PRESENCE_SAMPLE] <= RST_PRESENCE_SAMPLE;
            regs_reg[REG_PRESENCE_REST]   <= RST_PRESENCE_REST;
            regs_reg[REG_WRITE_LOW]       <= RST_WRITE_LOW;
            regs_reg[REG_WRITE_REST]      <= RST_WRITE_REST;
            regs_reg[REG_READ_LOW]        <= RST_READ_LOW;
            regs_reg[REG_READ_SAMPLE]     <= RST_READ_SAMPLE;
            regs_reg[REG_READ_REST]       <= RST_READ_REST;
        end
        else if (cfg_we)
        begin
            regs_reg[cfg_index] <= cfg_data;
        end
    end

    assign regs = regs_reg;

endmodule

// ----- rtl/owtr_seq.sv -----
// ============================================================================
// owtr_seq
// Slot sequencer: holds the bus state and advances it by one microsecond
// tick whenever a word moves from the input register to the result register.
// ============================================================================
module owtr_seq
    import owtr_pkg::*;
#(
    parameter int TIMER_BITS = 10
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  logic      opcode,
    input  logic      bus_level,
    input  cfg_regs_t regs,
    output step_res_t res
);

    localparam int CW = ((TIMER_BITS > REG_WIDTH) ? TIMER_BITS : REG_WIDTH) + 1;

    logic                  busy_reg,    busy_next;
    stage_t                stage_reg,   stage_next;
    part_t                 part_reg,    part_next;
    logic [TIMER_BITS-1:0] timer_reg,   timer_next;
    logic [2:0]            bitcnt_reg,  bitcnt_next;
    logic [7:0]            shift_reg,   shift_next;
    logic [11:0]           raw_reg,     raw_next;
    logic                  pending_reg, pending_next;
    logic [7:0]            whole_reg,   whole_next;
    logic [13:0]           frac_reg,    frac_next;
    logic                  ok_reg,      ok_next;

    logic                  start;
    logic                  active;
    stage_t                cur_stage;
    part_t                 cur_part;
    logic [TIMER_BITS-1:0] cur_timer;
    logic [2:0]            cur_bit;
    logic [7:0]            cur_shift;
    logic                  cur_pending;
    kind_t                 kind;
    reg_val_t              dur;
    logic [TIMER_BITS:0]   t1;
    logic                  expire;
    logic                  drive;
    logic                  done;
    logic [7:0]            shift_fill;
    logic [7:0]            cmd;

    // A start request on an idle bus begins at the first reset low part.
    assign start       = !busy_reg && opcode;
    assign active      = busy_reg || start;
    assign cur_stage   = start ? STAGE_RESET0 : stage_reg;
    assign cur_part    = start ? PART_LOW : part_reg;
    assign cur_timer   = start ? '0 : timer_reg;
    assign cur_bit     = start ? 3'd0 : bitcnt_reg;
    assign cur_shift   = start ? 8'd0 : shift_reg;
    assign cur_pending = start ? 1'b0 : pending_reg;
    assign kind        = stage_kind(cur_stage);
    assign cmd         = stage_command(cur_stage);
    assign shift_fill  = cur_shift | (8'(cur_pending) << cur_bit);

    // Duration of the current part from the register file.
    always_comb
    begin
        case (kind)
            KIND_RESET:
            begin
                case (cur_part)
                    PART_LOW:    dur = regs[REG_RESET_LOW];
                    PART_SAMPLE: dur = regs[REG_PRESENCE_SAMPLE];
                    default:     dur = regs[REG_PRESENCE_REST];
                endcase
            end
            KIND_WRITE:
            begin
                case (cur_part)
                    PART_LOW: dur = regs[REG_WRITE_LOW];
                    default:  dur = regs[REG_WRITE_REST];
                endcase
            end
            default:
            begin
                case (cur_part)
                    PART_LOW:    dur = regs[REG_READ_LOW];
                    PART_SAMPLE: dur = regs[REG_READ_SAMPLE];
                    default:     dur = regs[REG_READ_REST];
                endcase
            end
        endcase
    end

    // A part ends when its count is reached, a zero count acting as one tick,
    // or when the timer would wrap.
    assign t1     = {1'b0, cur_timer} + (TIMER_BITS+1)'(1);
    assign expire = (CW'(t1) >= CW'(dur)) || t1[TIMER_BITS];

    // Line drive and next state for one tick.
    always_comb
    begin
        busy_next    = busy_reg;
        stage_next   = stage_reg;
        part_next    = part_reg;
        timer_next   = timer_reg;
        bitcnt_next  = bitcnt_reg;
        shift_next   = shift_reg;
        raw_next     = raw_reg;
        pending_next = pending_reg;
        whole_next   = whole_reg;
        frac_next    = frac_reg;
        ok_next      = ok_reg;
        drive        = 1'b0;
        done         = 1'b0;

        if (active)
        begin
            busy_next    = 1'b1;
            stage_next   = cur_stage;
            part_next    = cur_part;
            bitcnt_next  = cur_bit;
            shift_next   = cur_shift;
            pending_next = cur_pending;
            timer_next   = expire ? '0 : t1[TIMER_BITS-1:0];

            if (cur_part == PART_LOW)
            begin
                drive = 1'b1;
            end
            else if (kind == KIND_WRITE)
            begin
                drive = ~cmd[cur_bit];
            end

            if (expire)
            begin
                if (cur_part == PART_LOW)
                begin
                    part_next = PART_SAMPLE;
                end
                else if (cur_part == PART_SAMPLE && kind != KIND_WRITE)
                begin
                    pending_next = bus_level;
                    part_next    = PART_REST;
                end
                else
                begin
                    // End of a whole slot.
                    part_next = PART_LOW;
                    case (kind)
                        KIND_RESET:
                        begin
                            if (cur_pending)
                            begin
                                // No presence pulse: abort.
                                ok_next   = 1'b0;
                                busy_next = 1'b0;
                                done      = 1'b1;
                            end
                            else if (cur_stage == STAGE_LAST)
                            begin
                                whole_next = raw_reg[11:4];
                                frac_next  = 14'(raw_reg[3:0]) * FRACTION_SCALE;
                                ok_next    = 1'b1;
                                busy_next  = 1'b0;
                                done       = 1'b1;
                            end
                            else
                            begin
                                stage_next  = cur_stage + stage_t'(1);
                                bitcnt_next = 3'd0;
                            end
                        end
                        KIND_WRITE:
                        begin
                            if (cur_bit == 3'd7)
                            begin
                                stage_next  = cur_stage + stage_t'(1);
                                bitcnt_next = 3'd0;
                            end
                            else
                            begin
                                bitcnt_next = cur_bit + 3'd1;
                            end
                        end
                        default:
                        begin
                            if (cur_stage == STAGE_POLL)
                            begin
                                // Conversion poll repeats until the line reads 1.
                                if (cur_pending)
                                begin
                                    stage_next  = cur_stage + stage_t'(1);
                                    bitcnt_next = 3'd0;
                                end
                            end
                            else if (cur_bit == 3'd7)
                            begin
                                if (cur_stage == STAGE_BYTE0)
                                begin
                                    raw_next = {4'd0, shift_fill};
                                end
                                else
                                begin
                                    raw_next = {raw_reg[11:8] | shift_fill[3:0],
                                                raw_reg[7:0]};
                                end
                                shift_next  = 8'd0;
                                stage_next  = cur_stage + stage_t'(1);
                                bitcnt_next = 3'd0;
                            end
                            else
                            begin
                                shift_next  = shift_fill;
                                bitcnt_next = cur_bit + 3'd1;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // State registers advance only when a tick is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            stage_reg   <= STAGE_RESET0;
            part_reg    <= PART_LOW;
            timer_reg   <= '0;
            bitcnt_reg  <= 3'd0;
            shift_reg   <= 8'd0;
            raw_reg     <= 12'd0;
            pending_reg <= 1'b0;
            whole_reg   <= 8'd0;
            frac_reg    <= 14'd0;
            ok_reg      <= 1'b0;
        end
        else if (step)
        begin
            busy_reg    <= busy_next;
            stage_reg   <= stage_next;
            part_reg    <= part_next;
            timer_reg   <= timer_next;
            bitcnt_reg  <= bitcnt_next;
            shift_reg   <= shift_next;
            raw_reg     <= raw_next;
            pending_reg <= pending_next;
            whole_reg   <= whole_next;
            frac_reg    <= frac_next;
            ok_reg      <= ok_next;
        end
    end

    assign res.drive_low = drive;
    assign res.busy      = busy_next;
    assign res.done      = done;
    assign res.ok        = ok_next;
    assign res.whole     = whole_next;
    assign res.fraction  = frac_next;

endmodule
